// ----- rtl/core/tkt_pkg.sv -----
// ----------------------------------------------------------------------------
// tkt_pkg
// Shared widths, defaults and the queued item type for the top-K tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tkt_pkg;

  localparam int IDX_W         = 20;
  localparam int ID_W          = 21;
  localparam int CNT_W         = 16;
  localparam int RANK_W        = 6;
  localparam int TOP_COUNT_DEF = 10;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] count;
    logic             last;
  } tkt_item_t;

endpackage

`default_nettype wire

// ----- rtl/core/tkt_front.sv -----
// ----------------------------------------------------------------------------
// tkt_front
// Input side: holds id_base, forms the item id and pushes items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tkt_front
  import tkt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [IDX_W-1:0] local_index,
  input  wire logic [CNT_W-1:0] item_count,
  input  wire logic             end_of_set,
  output logic                  push,
  output tkt_item_t             push_item,
  input  wire logic             q_ready
);

  logic [IDX_W-1:0] id_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_base <= '0;
    end else if (cfg_we) begin
      id_base <= cfg_wdata;
    end
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // id is the 21-bit sum of id_base and local_index and never wraps
  always_comb begin
    push_item.id    = ID_W'(id_base) + ID_W'(local_index);
    push_item.count = item_count;
    push_item.last  = end_of_set;
  end

endmodule

`default_nettype wire

// ----- rtl/core/tkt_queue.sv -----
// ----------------------------------------------------------------------------
// tkt_queue
// Two-entry item queue between the front and back sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tkt_queue
  import tkt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire tkt_item_t push_item,
  output logic           q_ready,
  output logic           head_valid,
  output tkt_item_t      head_item,
  input  wire logic      pop
);

  localparam int DEPTH = 2;

  tkt_item_t        slots [DEPTH];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign q_ready    = (fill != 2'(DEPTH));
  assign head_valid = (fill != 2'd0);
  assign head_item  = slots[rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/core/tkt_back.sv -----
// ----------------------------------------------------------------------------
// tkt_back
// Sorted top-K list with parallel compare / shift-insert, plus the emit
// buffer that streams a snapshot of the list out one slot per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tkt_back
  import tkt_pkg::*;
#(
  parameter int TOP_COUNT = TOP_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire tkt_item_t         head_item,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [RANK_W-1:0]      rank_position,
  output logic [ID_W-1:0]        entry_id,
  output logic [CNT_W-1:0]       entry_count,
  output logic                   last_of_list
);

  localparam logic [RANK_W-1:0] LAST_RANK = RANK_W'(TOP_COUNT - 1);

  logic [ID_W-1:0]  kept_ids    [TOP_COUNT];
  logic [CNT_W-1:0] kept_counts [TOP_COUNT];
  logic [ID_W-1:0]  ids_next    [TOP_COUNT];
  logic [CNT_W-1:0] counts_next [TOP_COUNT];
  logic [TOP_COUNT-1:0] ge;

  logic [ID_W-1:0]  emit_ids    [TOP_COUNT];
  logic [CNT_W-1:0] emit_counts [TOP_COUNT];
  logic             busy;
  logic [RANK_W-1:0] rank;

  logic last_beat;
  logic emit_free;
  logic load;

  assign last_beat = busy && out_ready && (rank == LAST_RANK);
  assign emit_free = !busy || last_beat;
  // an end-of-set item waits until the emit buffer can take the snapshot
  assign pop       = head_valid && (!head_item.last || emit_free);
  assign load      = pop && head_item.last;

  // A slot keeps its entry if it is >= the new count; the first slot below
  // takes the item and the rest shift down. If the item does not beat the
  // bottom slot, every ge bit is set and the list is unchanged.
  for (genvar k = 0; k < TOP_COUNT; k++) begin : g_ins
    assign ge[k] = (kept_counts[k] >= head_item.count);
    if (k == 0) begin : g_head
      always_comb begin
        if (ge[k]) begin
          ids_next[k]    = kept_ids[k];
          counts_next[k] = kept_counts[k];
        end else begin
          ids_next[k]    = head_item.id;
          counts_next[k] = head_item.count;
        end
      end
    end else begin : g_rest
      always_comb begin
        if (ge[k]) begin
          ids_next[k]    = kept_ids[k];
          counts_next[k] = kept_counts[k];
        end else if (ge[k-1]) begin
          ids_next[k]    = head_item.id;
          counts_next[k] = head_item.count;
        end else begin
          ids_next[k]    = kept_ids[k-1];
          counts_next[k] = kept_counts[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      for (int k = 0; k < TOP_COUNT; k++) begin
        kept_ids[k]    <= '0;
        kept_counts[k] <= '0;
      end
    end else if (pop) begin
      kept_ids    <= ids_next;
      kept_counts <= counts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rank <= '0;
    end else if (load) begin
      busy <= 1'b1;
      rank <= '0;
    end else if (busy && out_ready) begin
      rank <= rank + RANK_W'(1);
      if (rank == LAST_RANK) busy <= 1'b0;
    end
  end

  // emit buffer: snapshot on load, shift toward slot 0 on each beat
  for (genvar k = 0; k < TOP_COUNT; k++) begin : g_emit
    always_ff @(posedge clk) begin
      if (load) begin
        emit_ids[k]    <= ids_next[k];
        emit_counts[k] <= counts_next[k];
      end else if (busy && out_ready) begin
        if (k < TOP_COUNT - 1) begin
          emit_ids[k]    <= emit_ids[(k + 1) % TOP_COUNT];
          emit_counts[k] <= emit_counts[(k + 1) % TOP_COUNT];
        end
      end
    end
  end

  assign out_valid     = busy;
  assign rank_position = rank;
  assign entry_id      = emit_ids[0];
  assign entry_count   = emit_counts[0];
  assign last_of_list  = (rank == LAST_RANK);

  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 1; k < TOP_COUNT; k++) begin
      if (kept_counts[k] > kept_counts[k-1]) sorted_ok = 1'b0;
    end
  end

  a_sorted: assert property (@(posedge clk) disable iff (rst) sorted_ok)
    else $error("kept list out of order");

  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    load |=> (kept_counts[0] == '0))
    else $error("list not cleared after snapshot");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rank <= LAST_RANK))
    else $error("emit rank past end of list");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (busy && !out_ready) |=> (busy && $stable(rank)))
    else $error("emit buffer moved without a beat");

endmodule

`default_nettype wire

// ----- rtl/core/top_k_tracker.sv -----
// Order: an item is written into the queue and updates the list when it is
//   popped; an end_of_set item also loads the emit buffer at that pop.
// Throughput: one item per cycle through compare/insert, except that an
//   end_of_set item emits TOP_COUNT beats and a following end_of_set item
//   waits in the two-entry queue until the previous list is drained.
// Reset: list, id_base, queue pointers and emit busy/rank state clear.
// ----------------------------------------------------------------------------
// top_k_tracker
// Running top-K selection over (index, count) items; emits the sorted list
// on end_of_set and clears it.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_tracker
  import tkt_pkg::*;
#(
  parameter int TOP_COUNT = TOP_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [IDX_W-1:0]  local_index,
  input  wire logic [CNT_W-1:0]  item_count,
  input  wire logic              end_of_set,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [RANK_W-1:0]      rank_position,
  output logic [ID_W-1:0]        entry_id,
  output logic [CNT_W-1:0]       entry_count,
  output logic                   last_of_list
);

  logic      push;
  tkt_item_t push_item;
  logic      q_ready;
  logic      head_valid;
  tkt_item_t head_item;
  logic      pop;

  tkt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .local_index (local_index),
    .item_count  (item_count),
    .end_of_set  (end_of_set),
    .push        (push),
    .push_item   (push_item),
    .q_ready     (q_ready)
  );

  tkt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .q_ready    (q_ready),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  tkt_back #(
    .TOP_COUNT (TOP_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rank_position (rank_position),
    .entry_id      (entry_id),
    .entry_count   (entry_count),
    .last_of_list  (last_of_list)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top_k_tracker.sv -----
// ----------------------------------------------------------------------------
// tb_top_k_tracker
// Self-checking bench for the top-K tracker. Streams scored items over a
// valid/ready handshake and predicts the sorted list that each end_of_set
// item releases, under several id_base settings, random idling on both
// sides and one long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top_k_tracker
  import tkt_pkg::*;
();

  localparam int TOP_N        = TOP_COUNT_DEF;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS  = 72;
  localparam int NUM_PHASES   = 6;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   id;
    logic [CNT_W-1:0]  count;
    logic              last;
  } list_beat_t;

  class topk_scoreboard;
    logic [ID_W-1:0]  kept_id[TOP_N];
    logic [CNT_W-1:0] kept_cnt[TOP_N];
    logic [IDX_W-1:0] base;
    list_beat_t       pending_beats[$];
    int               errors;
    int               items_noted;
    int               lists_emitted;
    int               beats_checked;

    function new();
      base = '0;
      clear_list();
    endfunction

    function void clear_list();
      for (int k = 0; k < TOP_N; k++) begin
        kept_id[k]  = '0;
        kept_cnt[k] = '0;
      end
    endfunction

    function void set_base(logic [IDX_W-1:0] value);
      base = value;
    endfunction

    // Insert below all equal counts; ties with the smallest entry are dropped.
    function void note_item(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt, logic last);
      logic [ID_W-1:0] id;
      int              pos;
      list_beat_t      b;
      id = {1'b0, base} + {1'b0, idx};
      items_noted++;
      if (cnt > kept_cnt[TOP_N-1]) begin
        pos = 0;
        while (pos < TOP_N - 1 && kept_cnt[pos] >= cnt) pos++;
        for (int k = TOP_N - 1; k > pos; k--) begin
          kept_id[k]  = kept_id[k-1];
          kept_cnt[k] = kept_cnt[k-1];
        end
        kept_id[pos]  = id;
        kept_cnt[pos] = cnt;
      end
      if (last) begin
        for (int k = 0; k < TOP_N; k++) begin
          b.rank  = k[RANK_W-1:0];
          b.id    = kept_id[k];
          b.count = kept_cnt[k];
          b.last  = (k == TOP_N - 1);
          pending_beats.push_back(b);
        end
        lists_emitted++;
        clear_list();
      end
    endfunction

    function void check_beat(logic [RANK_W-1:0] rank, logic [ID_W-1:0] id,
                             logic [CNT_W-1:0] cnt, logic last);
      list_beat_t b;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: rank %0d id %0h count %0h", rank, id, cnt);
        errors++;
        return;
      end
      b = pending_beats.pop_front();
      beats_checked++;
      if (rank !== b.rank) begin
        $error("rank_position mismatch: expected %0d, got %0d", b.rank, rank);
        errors++;
      end
      if (id !== b.id) begin
        $error("entry_id mismatch: expected %0h, got %0h", b.id, id);
        errors++;
      end
      if (cnt !== b.count) begin
        $error("entry_count mismatch: expected %0h, got %0h", b.count, cnt);
        errors++;
      end
      if (last !== b.last) begin
        $error("last_of_list mismatch: expected %0b, got %0b", b.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_beats.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IDX_W-1:0]  local_index = '0;
  logic [CNT_W-1:0]  item_count = '0;
  logic              end_of_set = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [RANK_W-1:0] rank_position;
  logic [ID_W-1:0]   entry_id;
  logic [CNT_W-1:0]  entry_count;
  logic              last_of_list;

  topk_scoreboard sb;
  int             tx_gap_max = 16;
  int             rx_gap_max = 16;
  int             rx_hold_req = 0;
  int             cycle_count = 0;
  int             base_writes = 0;

  top_k_tracker #(
    .TOP_COUNT(TOP_N)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .local_index  (local_index),
    .item_count   (item_count),
    .end_of_set   (end_of_set),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .rank_position(rank_position),
    .entry_id     (entry_id),
    .entry_count  (entry_count),
    .last_of_list (last_of_list)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top_k_tracker failed");
      $finish;
    end
  end

  // Called at a falling edge while the block is idle.
  task automatic write_base(logic [IDX_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_base(value);
    base_writes++;
  endtask

  // Valid stays high across back-to-back beats; it only drops for a gap.
  task automatic send_item(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt, logic last);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    local_index = idx;
    item_count  = cnt;
    end_of_set  = last;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_item(idx, cnt, last);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_set(int len);
    int               mode;
    logic [CNT_W-1:0] cnt;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: cnt = CNT_W'($urandom_range(0, 16'hFFFF));
        1: cnt = CNT_W'($urandom_range(0, 15));          // heavy ties and zeros
        2: cnt = CNT_W'($urandom_range(16'hFFF0, 16'hFFFF));
        default: cnt = ($urandom_range(0, 3) == 0) ? '0 : CNT_W'($urandom_range(0, 16'hFFFF));
      endcase
      send_item(IDX_W'($urandom_range(0, 20'hFFFFF)), cnt, i == len - 1);
    end
  endtask

  // Output side: random ready gaps plus an optional long hold.
  initial begin
    int gap;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (rx_hold_req > 0) begin
        out_ready = 1'b0;
        repeat (rx_hold_req) @(negedge clk);
        rx_hold_req = 0;
      end
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_beat(rank_position, entry_id, entry_count, last_of_list);
      @(negedge clk);
    end
  end

  initial begin
    int  phase_items;
    int  len;
    bit  pressure;
    sb = new();
    repeat (2) @(negedge clk);
    rst = 1'b0;

    write_base('0);
    // empty list, extremes of index and count, zero count never enters
    send_item(20'h00000, 16'h0000, 1'b1);
    send_item(20'h00000, 16'hFFFF, 1'b0);
    send_item(20'hFFFFF, 16'h0000, 1'b0);
    send_item(20'hFFFFF, 16'h0001, 1'b0);
    send_item(20'h00005, 16'h8000, 1'b1);
    // fill with equal counts, then a tie with the smallest must not enter
    for (int i = 1; i <= TOP_N; i++) send_item(IDX_W'(i), 16'h0007, 1'b0);
    send_item(20'd11, 16'h0007, 1'b0);
    send_item(20'd12, 16'h0009, 1'b0);
    send_item(20'd13, 16'h0008, 1'b0);
    send_item(20'd15, 16'h0009, 1'b0);             // lands below the earlier 9
    send_item(20'd14, 16'h0007, 1'b1);
    wait_drained();

    write_base(20'hFFFFF);                         // id reaches bit 20
    send_item(20'hFFFFF, 16'hFFFF, 1'b0);
    send_item(20'h00000, 16'hFFFF, 1'b0);
    send_item(20'hAAAAA, 16'h5555, 1'b1);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      pressure = (p == 3);
      case (p)
        0: write_base(20'hFFFFF);
        1: write_base('0);
        4: write_base(20'h00001);
        default: write_base(IDX_W'($urandom_range(0, 20'hFFFFF)));
      endcase
      tx_gap_max = (p == 1 || p == 3 || p == 4) ? 0 : 16;
      rx_gap_max = (p == 1 || p == 2) ? 0 : 16;
      if (pressure) rx_hold_req = 300;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (pressure) len = $urandom_range(1, 3);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(25, 45);
        else len = $urandom_range(1, 16);
        send_random_set(len);
        phase_items += len;
      end
      wait_drained();
    end

    repeat (20) @(negedge clk);
    $display("covered %0d items in %0d lists, %0d result beats checked",
             sb.items_noted, sb.lists_emitted, sb.beats_checked);
    $display("id_base written %0d times, including 0 and the all-ones value", base_writes);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_top_k_tracker passed");
    end else begin
      $display("tb_top_k_tracker failed");
    end
    $finish;
  end

endmodule
